>>> rtl/core/sfd_pkg.sv
// Package for the sensor frame deframer: status codes, constants and the
// result item type. Used by the top level and by its checker.
// No dependencies.
`default_nettype none

package sfd_pkg;

  localparam logic [1:0] STATUS_BODY      = 2'd0;
  localparam logic [1:0] STATUS_IDLE      = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd2;
  localparam logic [1:0] STATUS_LENGTH    = 2'd3;

  localparam logic [7:0]  ALL_ONES_BYTE   = 8'hFF;
  localparam logic [7:0]  BODY_CHECK_BASE = 8'hAA;
  localparam logic [15:0] CAPACITY_RESET  = 16'd4096;

  localparam logic [1:0]  REG_BODY_CAPACITY = 2'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] body_length;
    logic        is_last;
    logic [7:0]  body_check;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/sensor_frame_deframer.sv
// Sensor frame deframer: takes one received byte per item and gives one
// result per body byte and one per rejected header. The block accepts one
// byte every cycle while in_stall is low; each result is registered into the
// output register, or into a one-entry skid stage while the output is stalled, so input
// stall rises only when both the output register and the skid stage hold a result.
// body_capacity sits at byte address 0 of the APB port and resets to 4096.
// Depends on sfd_pkg.
`default_nettype none

module sensor_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [7:0]       data_byte,
  output logic [7:0]       frame_type,
  output logic [15:0]      body_length,
  output logic             is_last,
  output logic [7:0]       body_check,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0] body_capacity;

  logic        in_body,        in_body_next;
  logic [1:0]  header_count,   header_count_next;
  logic [7:0]  held_type,      held_type_next;
  logic [15:0] held_length,    held_length_next;
  logic [7:0]  header_sum,     header_sum_next;
  logic        all_ones_seen,  all_ones_seen_next;
  logic [15:0] body_remaining, body_remaining_next;
  logic [7:0]  body_sum,       body_sum_next;

  sfd_pkg::res_t res, out_res, skid_res;
  logic          res_valid;
  logic          skid_valid;
  logic          accept;
  logic          body_now;
  logic [1:0]    count_now;
  logic          byte_ones;

  assign pready   = 1'b1;
  assign prdata   = (paddr == sfd_pkg::REG_BODY_CAPACITY) ? {16'd0, body_capacity} : 32'd0;
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_capacity <= sfd_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == sfd_pkg::REG_BODY_CAPACITY) begin
      body_capacity <= pwdata[15:0];
    end
  end

  always_comb begin
    in_body_next        = in_body;
    header_count_next   = header_count;
    held_type_next      = held_type;
    held_length_next    = held_length;
    header_sum_next     = header_sum;
    all_ones_seen_next  = all_ones_seen;
    body_remaining_next = body_remaining;
    body_sum_next       = body_sum;
    res_valid           = 1'b0;
    res                 = '0;
    body_now            = in_body && !frame_start;
    count_now           = frame_start ? 2'd0 : header_count;
    byte_ones           = (rx_byte == sfd_pkg::ALL_ONES_BYTE);

    if (frame_start || in_body || header_count != 2'd0) begin
      if (body_now) begin
        body_sum_next       = body_sum + rx_byte;
        body_remaining_next = body_remaining - 16'd1;
        res_valid           = 1'b1;
        res.status          = sfd_pkg::STATUS_BODY;
        res.data_byte       = rx_byte;
        res.frame_type      = held_type;
        res.body_length     = held_length;
        if (body_remaining_next == 16'd0) begin
          in_body_next   = 1'b0;
          res.is_last    = 1'b1;
          res.body_check = sfd_pkg::BODY_CHECK_BASE - body_sum_next;
        end
      end else begin
        in_body_next = 1'b0;
        case (count_now)
          2'd0: begin
            held_type_next     = rx_byte;
            header_sum_next    = rx_byte;
            all_ones_seen_next = byte_ones;
            header_count_next  = 2'd1;
          end
          2'd1: begin
            held_length_next   = {held_length[15:8], rx_byte};
            header_sum_next    = header_sum + rx_byte;
            all_ones_seen_next = all_ones_seen && byte_ones;
            header_count_next  = 2'd2;
          end
          2'd2: begin
            held_length_next   = {rx_byte, held_length[7:0]};
            header_sum_next    = header_sum + rx_byte;
            all_ones_seen_next = all_ones_seen && byte_ones;
            header_count_next  = 2'd3;
          end
          default: begin
            header_count_next = 2'd0;
            res.frame_type    = held_type;
            res.body_length   = held_length;
            res.is_last       = 1'b1;
            if (all_ones_seen && byte_ones) begin
              res_valid  = 1'b1;
              res.status = sfd_pkg::STATUS_IDLE;
            end else if (header_sum != rx_byte) begin
              res_valid  = 1'b1;
              res.status = sfd_pkg::STATUS_CHECKSUM;
            end else if (held_length == 16'd0 || held_length > body_capacity) begin
              res_valid  = 1'b1;
              res.status = sfd_pkg::STATUS_LENGTH;
            end else begin
              in_body_next        = 1'b1;
              body_remaining_next = held_length;
              body_sum_next       = 8'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body        <= 1'b0;
      header_count   <= 2'd0;
      held_type      <= 8'd0;
      held_length    <= 16'd0;
      header_sum     <= 8'd0;
      all_ones_seen  <= 1'b1;
      body_remaining <= 16'd0;
      body_sum       <= 8'd0;
    end else if (accept) begin
      in_body        <= in_body_next;
      header_count   <= header_count_next;
      held_type      <= held_type_next;
      held_length    <= held_length_next;
      header_sum     <= header_sum_next;
      all_ones_seen  <= all_ones_seen_next;
      body_remaining <= body_remaining_next;
      body_sum       <= body_sum_next;
    end
  end

  // output register with one-entry skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || (accept && res_valid);
      skid_valid <= 1'b0;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

  assign status      = out_res.status;
  assign data_byte   = out_res.data_byte;
  assign frame_type  = out_res.frame_type;
  assign body_length = out_res.body_length;
  assign is_last     = out_res.is_last;
  assign body_check  = out_res.body_check;

endmodule

`default_nettype wire

>>> rtl/core/sfd_checker.sv
// Port-level checker for the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg and sensor_frame_deframer.
`default_nettype none

module sfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [7:0]  data_byte,
  input wire logic        is_last,
  input wire logic [7:0]  body_check
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sfd_pkg::STATUS_BODY |-> is_last && data_byte == 8'd0 &&
    body_check == 8'd0)
    else $error("status item fields wrong");

  a_check_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> body_check == 8'd0 && status == sfd_pkg::STATUS_BODY)
    else $error("body check outside last byte");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .data_byte  (data_byte),
  .is_last    (is_last),
  .body_check (body_check)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for sensor_frame_deframer: a directed table, then random frames under several
// body capacities; each result is checked against a table item or the in-bench deframer.
// Depends on sfd_pkg and the sensor_frame_deframer RTL.

module tb;

  localparam int LIMIT = 400000;
  localparam logic [1:0] CAP_ADDR = 2'(4 * sfd_pkg::REG_BODY_CAPACITY);

  typedef struct {
    logic [7:0]    b;
    logic          s;
    bit            typed;
    sfd_pkg::res_t r;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  data_byte;
  logic [7:0]  frame_type;
  logic [15:0] body_length;
  logic        is_last;
  logic [7:0]  body_check;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] capacity = sfd_pkg::CAPACITY_RESET;
  bit          open_body = 1'b0;
  logic [1:0]  hdr_idx = 2'd0;
  logic [7:0]  hdr_type = 8'h00;
  logic [15:0] hdr_len = 16'h0000;
  logic [7:0]  hdr_sum = 8'h00;
  bit          hdr_all_ones = 1'b1;
  logic [15:0] body_left = 16'h0000;
  logic [7:0]  body_sum = 8'h00;

  sfd_pkg::res_t due_results[$];
  stim_row_t     rows[$];
  int            faults = 0;
  int            sent = 0;
  int            cycles = 0;
  bit            calm = 1'b0;

  sensor_frame_deframer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .data_byte(data_byte),
    .frame_type(frame_type), .body_length(body_length), .is_last(is_last),
    .body_check(body_check),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 32);

  task automatic deframe(input logic [7:0] b, input logic s, output bit got,
                         output sfd_pkg::res_t r);
    r = '0;
    got = 1'b0;
    if (s) begin
      open_body = 1'b0;
      hdr_idx = 2'd0;
    end else if (!open_body && hdr_idx == 2'd0) begin
      return;
    end
    if (open_body) begin
      body_sum = body_sum + b;
      body_left = body_left - 16'd1;
      r.status = sfd_pkg::STATUS_BODY;
      r.data_byte = b;
      r.frame_type = hdr_type;
      r.body_length = hdr_len;
      if (body_left == 16'd0) begin
        open_body = 1'b0;
        r.is_last = 1'b1;
        r.body_check = sfd_pkg::BODY_CHECK_BASE - body_sum;
      end
      got = 1'b1;
      return;
    end
    case (hdr_idx)
      2'd0: begin
        hdr_type = b;
        hdr_sum = b;
        hdr_all_ones = (b == sfd_pkg::ALL_ONES_BYTE);
        hdr_idx = 2'd1;
      end
      2'd1: begin
        hdr_len = {8'h00, b};
        hdr_sum = hdr_sum + b;
        hdr_all_ones = hdr_all_ones && (b == sfd_pkg::ALL_ONES_BYTE);
        hdr_idx = 2'd2;
      end
      2'd2: begin
        hdr_len[15:8] = b;
        hdr_sum = hdr_sum + b;
        hdr_all_ones = hdr_all_ones && (b == sfd_pkg::ALL_ONES_BYTE);
        hdr_idx = 2'd3;
      end
      default: begin
        hdr_idx = 2'd0;
        r.frame_type = hdr_type;
        r.body_length = hdr_len;
        r.is_last = 1'b1;
        got = 1'b1;
        if (hdr_all_ones && b == sfd_pkg::ALL_ONES_BYTE) begin
          r.status = sfd_pkg::STATUS_IDLE;
        end else if (hdr_sum != b) begin
          r.status = sfd_pkg::STATUS_CHECKSUM;
        end else if (hdr_len == 16'd0 || hdr_len > capacity) begin
          r.status = sfd_pkg::STATUS_LENGTH;
        end else begin
          got = 1'b0;
          open_body = 1'b1;
          body_left = hdr_len;
          body_sum = 8'h00;
        end
      end
    endcase
  endtask

  function automatic sfd_pkg::res_t rejected(input logic [1:0] st, input logic [7:0] t,
                                             input logic [15:0] len);
    sfd_pkg::res_t r;
    r = '0;
    r.status = st;
    r.frame_type = t;
    r.body_length = len;
    r.is_last = 1'b1;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                           input sfd_pkg::res_t fixed);
    bit            got;
    sfd_pkg::res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= s;
    do @(posedge clk); while (in_stall);
    if (s || open_body || hdr_idx != 2'd0) sent++;
    deframe(b, s, got, r);
    if (typed) due_results.push_back(fixed);
    else if (got) due_results.push_back(r);
  endtask

  task automatic random_frame();
    logic [7:0]  t;
    logic [7:0]  cs;
    logic [15:0] len;
    logic [7:0]  bytes[$];
    int          kind;
    int          lim;
    int          c;
    int          cut;
    c = capacity;
    kind = $urandom_range(0, 99);
    lim = ($urandom_range(0, 19) == 0) ? 400 : 24;
    if (lim > c) lim = c;
    t = 8'($urandom);
    len = (lim == 0) ? 16'd1 : 16'($urandom_range(1, lim));
    if (kind < 8) begin
      t = sfd_pkg::ALL_ONES_BYTE;
      len = 16'hFFFF;
    end else if (kind < 18) begin
      len = (c == 65535 || $urandom_range(0, 3) == 0) ? 16'd0
                                                       : 16'($urandom_range(c + 1, 65535));
    end
    cs = (kind < 8) ? sfd_pkg::ALL_ONES_BYTE : 8'(t + len[7:0] + len[15:8]);
    if (kind >= 18 && kind < 28) cs = cs ^ (8'h01 << $urandom_range(0, 7));
    bytes.push_back(t);
    bytes.push_back(len[7:0]);
    bytes.push_back(len[15:8]);
    bytes.push_back(cs);
    if (kind >= 28) repeat (len) bytes.push_back(8'($urandom));
    cut = bytes.size();
    if ($urandom_range(0, 11) == 0) cut = $urandom_range(1, bytes.size() - 1);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
    end
    for (int i = 0; i < cut; i++) send_byte(bytes[i], i == 0, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [1:0] a, input logic [15:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== want) begin
      faults++;
      if (faults <= 10) $display("capacity readback: expected %0d, got %0d", want, prdata[15:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_results
    sfd_pkg::res_t seen;
    sfd_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = {status, data_byte, frame_type, body_length, is_last, body_check};
      if (due_results.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected result: st=%0d data=%h type=%h len=%h last=%0d chk=%h",
                   seen.status, seen.data_byte, seen.frame_type,
                   seen.body_length, seen.is_last, seen.body_check);
        end
      end else begin
        want = due_results.pop_front();
        if (seen.status !== want.status || seen.data_byte !== want.data_byte ||
            seen.frame_type !== want.frame_type || seen.body_length !== want.body_length ||
            seen.is_last !== want.is_last || seen.body_check !== want.body_check) begin
          faults++;
          if (faults <= 10) begin
            $display("mismatch: expected st=%0d data=%h type=%h len=%h last=%0d chk=%h",
                     want.status, want.data_byte, want.frame_type, want.body_length,
                     want.is_last, want.body_check);
            $display("          got      st=%0d data=%h type=%h len=%h last=%0d chk=%h",
                     seen.status, seen.data_byte, seen.frame_type, seen.body_length,
                     seen.is_last, seen.body_check);
          end
        end
      end
    end
  end

  initial begin
    logic [15:0] next_cap;
    int          goal;
    rows.push_back('{8'h5A, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b1, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b0, 1'b1, rejected(sfd_pkg::STATUS_IDLE, 8'hFF, 16'hFFFF)});
    rows.push_back('{8'h12, 1'b1, 1'b0, '0});
    rows.push_back('{8'h03, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b1, rejected(sfd_pkg::STATUS_CHECKSUM, 8'h12, 16'h0003)});
    rows.push_back('{8'h00, 1'b1, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b1, rejected(sfd_pkg::STATUS_LENGTH, 8'h00, 16'h0000)});
    rows.push_back('{8'h80, 1'b1, 1'b0, '0});
    rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{8'h10, 1'b0, 1'b0, '0});
    rows.push_back('{8'h91, 1'b0, 1'b1, rejected(sfd_pkg::STATUS_LENGTH, 8'h80, 16'h1001)});
    rows.push_back('{8'h41, 1'b1, 1'b0, '0});
    rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b1, 1'b0, '0});
    rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{8'hFF, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_read_check(CAP_ADDR, sfd_pkg::CAPACITY_RESET);

    foreach (rows[i]) send_byte(rows[i].b, rows[i].s, rows[i].typed, rows[i].r);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: next_cap = 16'd1;
        1: next_cap = 16'hFFFF;
        2: next_cap = 16'd0;
        3: next_cap = sfd_pkg::CAPACITY_RESET;
        4: next_cap = 16'($urandom_range(2, 64));
        default: next_cap = 16'($urandom_range(1, 65535));
      endcase
      settle();
      apb_write(CAP_ADDR, {16'h0000, next_cap});
      capacity = next_cap;
      apb_read_check(CAP_ADDR, next_cap);
      calm = (p == 3);
      goal = sent + 292;
      while (sent < goal) random_frame();
    end

    settle();
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
